FILE: hdl/tcc_pkg.sv
// Package for the terminal character controller.
// Holds the shared types, command and status codes, and the receive FIFO sizing.
// No dependencies.
package tcc_pkg;

  localparam int RX_DEPTH = 32;
  localparam int PTR_W    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int CNT_W    = $clog2(RX_DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;

  localparam logic [3:0] KIND_READ    = 4'd0;
  localparam logic [3:0] KIND_WRITE   = 4'd1;
  localparam logic [3:0] KIND_DETACH  = 4'd2;
  localparam logic [3:0] KIND_RESET   = 4'd3;
  localparam logic [3:0] KIND_SPU     = 4'd4;
  localparam logic [3:0] KIND_INTSPEC = 4'd5;
  localparam logic [3:0] KIND_RX_CHAR = 4'd6;
  localparam logic [3:0] KIND_TX_DONE = 4'd7;
  localparam logic [3:0] KIND_SW_TMO  = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EN    = 2'd1;
  localparam logic [1:0] ST_NO    = 2'd2;
  localparam logic [1:0] ST_EVENT = 2'd3;

  localparam logic [1:0] CODE_NONE     = 2'd0;
  localparam logic [1:0] CODE_READY    = 2'd1;
  localparam logic [1:0] CODE_SLOW     = 2'd2;
  localparam logic [1:0] CODE_OUTDATED = 2'd3;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_OK  = 2'd1,
    MODE_EN  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_IN   = 2'd1,
    DIR_OUT  = 2'd2
  } dir_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_data;
    logic [1:0] int_code;
    logic       int_pulse;
    logic       int_pending;
    logic       tx_start;
    logic [7:0] tx_byte;
    logic       switch_request;
    logic       rx_room;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [PTR_W-1:0] raddr;
  } ram_req_t;

endpackage

FILE: hdl/tcc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: hdl/tcc_ctrl.sv
// Command and event sequencer: channel state, receive FIFO pointers, result build.
// Depends on tcc_pkg; drives the receive FIFO RAM through a request struct.
module tcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              unattended,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [3:0]        in_kind,
  input  logic [7:0]        in_data,
  input  logic              slot_free,
  output logic              done,
  output tcc_pkg::result_t  res,
  output tcc_pkg::ram_req_t ram_req,
  input  logic [7:0]        ram_rdata
);

  tcc_pkg::ctrl_state_t state_r, state_nxt;
  tcc_pkg::mode_t       mode_r, mode_nxt;
  tcc_pkg::dir_t        dir_r, dir_nxt;
  logic                 busy_r, busy_nxt;
  logic [1:0]           code_r, code_nxt;
  logic [7:0]           rxb_r, rxb_nxt;
  logic                 rxv_r, rxv_nxt;
  logic [tcc_pkg::PTR_W-1:0] head_r, head_nxt;
  logic [tcc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 swp_r, swp_nxt;
  logic [3:0]           kind_r;
  logic [7:0]           data_r;
  logic [tcc_pkg::SUM_W-1:0] wsum;
  logic [tcc_pkg::SUM_W-1:0] wsum_wrap;
  logic                 fifo_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcc_pkg::S_IDLE;
      mode_r  <= tcc_pkg::MODE_OFF;
      dir_r   <= tcc_pkg::DIR_NONE;
      busy_r  <= 1'b0;
      code_r  <= tcc_pkg::CODE_NONE;
      rxb_r   <= '0;
      rxv_r   <= 1'b0;
      head_r  <= '0;
      cnt_r   <= '0;
      swp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      dir_r   <= dir_nxt;
      busy_r  <= busy_nxt;
      code_r  <= code_nxt;
      rxb_r   <= rxb_nxt;
      rxv_r   <= rxv_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      swp_r   <= swp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_kind;
      data_r <= in_data;
    end
  end

  assign fifo_full = (cnt_r >= tcc_pkg::CNT_W'(tcc_pkg::RX_DEPTH));
  assign wsum      = tcc_pkg::SUM_W'(head_r) + tcc_pkg::SUM_W'(cnt_r);
  assign wsum_wrap = (wsum >= tcc_pkg::SUM_W'(tcc_pkg::RX_DEPTH))
                     ? wsum - tcc_pkg::SUM_W'(tcc_pkg::RX_DEPTH) : wsum;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    dir_nxt   = dir_r;
    busy_nxt  = busy_r;
    code_nxt  = code_r;
    rxb_nxt   = rxb_r;
    rxv_nxt   = rxv_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    swp_nxt   = swp_r;
    in_ready  = (state_r == tcc_pkg::S_IDLE);
    done      = 1'b0;
    res       = '0;
    res.status = tcc_pkg::ST_EVENT;
    ram_req.we    = 1'b0;
    ram_req.waddr = wsum_wrap[tcc_pkg::PTR_W-1:0];
    ram_req.wdata = data_r;
    ram_req.raddr = head_r;

    unique case (state_r)
      tcc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = tcc_pkg::S_EXEC;
        end
      end
      tcc_pkg::S_EXEC: begin
        if (slot_free) begin
          done      = 1'b1;
          state_nxt = tcc_pkg::S_IDLE;
          unique case (kind_r)
            tcc_pkg::KIND_READ: begin
              dir_nxt = tcc_pkg::DIR_IN;
              if (unattended ? (cnt_r != '0) : rxv_r) begin
                if (unattended) begin
                  res.read_data = ram_rdata;
                  head_nxt = (head_r == tcc_pkg::PTR_W'(tcc_pkg::RX_DEPTH - 1))
                             ? '0 : head_r + tcc_pkg::PTR_W'(1);
                  cnt_nxt  = cnt_r - tcc_pkg::CNT_W'(1);
                end else begin
                  res.read_data = rxb_r;
                  rxv_nxt = 1'b0;
                end
                mode_nxt   = tcc_pkg::MODE_OK;
                res.status = tcc_pkg::ST_OK;
              end else begin
                mode_nxt   = tcc_pkg::MODE_EN;
                res.status = tcc_pkg::ST_EN;
              end
            end
            tcc_pkg::KIND_WRITE: begin
              if (!busy_r && dir_r == tcc_pkg::DIR_OUT) begin
                mode_nxt    = tcc_pkg::MODE_OK;
                busy_nxt    = 1'b1;
                res.tx_start = 1'b1;
                res.tx_byte  = data_r;
                res.status   = tcc_pkg::ST_OK;
              end else begin
                if (dir_r != tcc_pkg::DIR_OUT && !swp_r) begin
                  swp_nxt = 1'b1;
                  res.switch_request = 1'b1;
                end
                mode_nxt   = tcc_pkg::MODE_EN;
                res.status = tcc_pkg::ST_EN;
              end
            end
            tcc_pkg::KIND_DETACH: begin
              if (!busy_r) begin
                mode_nxt   = tcc_pkg::MODE_OFF;
                dir_nxt    = tcc_pkg::DIR_NONE;
                head_nxt   = '0;
                cnt_nxt    = '0;
                rxv_nxt    = 1'b0;
                res.status = tcc_pkg::ST_OK;
              end else begin
                mode_nxt   = tcc_pkg::MODE_EN;
                res.status = tcc_pkg::ST_EN;
              end
            end
            tcc_pkg::KIND_RESET: begin
              mode_nxt   = tcc_pkg::MODE_OFF;
              dir_nxt    = tcc_pkg::DIR_NONE;
              busy_nxt   = 1'b0;
              head_nxt   = '0;
              cnt_nxt    = '0;
              rxv_nxt    = 1'b0;
              res.status = tcc_pkg::ST_OK;
            end
            tcc_pkg::KIND_SPU: begin
              res.status = tcc_pkg::ST_OK;
            end
            tcc_pkg::KIND_INTSPEC: begin
              res.int_code = code_r;
              code_nxt     = tcc_pkg::CODE_OUTDATED;
              mode_nxt     = tcc_pkg::MODE_OK;
              res.status   = tcc_pkg::ST_OK;
            end
            tcc_pkg::KIND_RX_CHAR: begin
              if (dir_r == tcc_pkg::DIR_IN && mode_r != tcc_pkg::MODE_OFF) begin
                if (unattended) begin
                  if (fifo_full) begin
                    code_nxt = tcc_pkg::CODE_SLOW;
                  end else begin
                    ram_req.we = 1'b1;
                    cnt_nxt    = cnt_r + tcc_pkg::CNT_W'(1);
                    if (mode_r == tcc_pkg::MODE_EN) begin
                      code_nxt = tcc_pkg::CODE_READY;
                    end
                  end
                end else begin
                  if (rxv_r) begin
                    code_nxt = tcc_pkg::CODE_SLOW;
                  end else if (mode_r == tcc_pkg::MODE_EN) begin
                    code_nxt = tcc_pkg::CODE_READY;
                  end
                  rxb_nxt = data_r;
                  rxv_nxt = 1'b1;
                end
                res.int_pulse = 1'b1;
              end
            end
            tcc_pkg::KIND_TX_DONE: begin
              busy_nxt = 1'b0;
              if (mode_r == tcc_pkg::MODE_EN) begin
                code_nxt      = tcc_pkg::CODE_READY;
                res.int_pulse = 1'b1;
              end
            end
            tcc_pkg::KIND_SW_TMO: begin
              swp_nxt = 1'b0;
              if (mode_r != tcc_pkg::MODE_OFF) begin
                dir_nxt = tcc_pkg::DIR_OUT;
                if (mode_r == tcc_pkg::MODE_EN) begin
                  code_nxt      = tcc_pkg::CODE_READY;
                  res.int_pulse = 1'b1;
                end
              end
            end
            default: begin
              res.status = tcc_pkg::ST_NO;
            end
          endcase
          res.int_pending = (code_nxt == tcc_pkg::CODE_READY) ||
                            (code_nxt == tcc_pkg::CODE_SLOW);
          res.rx_room = unattended ? (cnt_nxt < tcc_pkg::CNT_W'(tcc_pkg::RX_DEPTH)) : 1'b1;
        end
      end
      default: begin
        state_nxt = tcc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/terminal_char_controller.sv
// A result beat is registered into the output slot from the execute state that
// follows an accepted input beat, once the slot is free; the FIFO RAM read data
// is registered and used there. No input beat is accepted outside the idle state.
// Reset: synchronous, active-low rst_n clears all control state; FIFO RAM
// contents are not cleared and need no clearing pass.
// Top level of the terminal character controller; depends on tcc_pkg, tcc_ram, tcc_ctrl.
module terminal_char_controller (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_kind,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_read_data,
  output logic [1:0] out_int_code,
  output logic       out_int_pulse,
  output logic       out_int_pending,
  output logic       out_tx_start,
  output logic [7:0] out_tx_byte,
  output logic       out_switch_request,
  output logic       out_rx_room
);

  logic              unattended_r;
  logic              out_valid_r;
  tcc_pkg::result_t  out_res_r;
  tcc_pkg::result_t  res;
  tcc_pkg::ram_req_t ram_req;
  logic [7:0]        ram_rdata;
  logic              done;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unattended_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unattended_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res_r <= res;
    end
  end

  tcc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .unattended (unattended_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_data    (in_data),
    .slot_free  (slot_free),
    .done       (done),
    .res        (res),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata)
  );

  tcc_ram #(
    .WIDTH (8),
    .DEPTH (tcc_pkg::RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_read_data      = out_res_r.read_data;
  assign out_int_code       = out_res_r.int_code;
  assign out_int_pulse      = out_res_r.int_pulse;
  assign out_int_pending    = out_res_r.int_pending;
  assign out_tx_start       = out_res_r.tx_start;
  assign out_tx_byte        = out_res_r.tx_byte;
  assign out_switch_request = out_res_r.switch_request;
  assign out_rx_room        = out_res_r.rx_room;

endmodule

FILE: hdl/tcc_checker.sv
// Port-level checker for the terminal character controller, bound to the top level.
// Depends on tcc_pkg for the status codes.
module tcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic       out_int_pulse,
  input logic       out_tx_start,
  input logic [7:0] out_tx_byte
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result beat dropped while stalled");

  // a send only comes with an ok status
  a_tx_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_start |-> out_status == tcc_pkg::ST_OK)
    else $error("tx_start without ok status");

  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_start |-> out_tx_byte == 8'd0)
    else $error("tx_byte nonzero without tx_start");

  // interrupt pulses come only from terminal events
  a_pulse_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_int_pulse |-> out_status == tcc_pkg::ST_EVENT)
    else $error("interrupt pulse on a command");

  // hold off the next input beat while the accepted one executes
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

endmodule

bind terminal_char_controller tcc_checker u_tcc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_int_pulse (out_int_pulse),
  .out_tx_start  (out_tx_start),
  .out_tx_byte   (out_tx_byte)
);

FILE: tb/sv/terminal_char_controller_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for terminal_char_controller: directed command and event
// sequences, then randomized sessions in both receive modes, checked against a predictor.
// Depends on tcc_pkg and the terminal_char_controller RTL.
module terminal_char_controller_tb;

  localparam logic [3:0] KIND_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] KIND_UNKNOWN_HI = 4'd15;
  localparam int         ITEM_TARGET     = 1550;
  localparam int         MAX_GAP         = 12;
  localparam int         DRAIN_CYCLES    = 4;
  localparam int         STALL_LIMIT     = 1000;
  localparam int         MAX_REPORTS     = 10;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid    = 1'b0;
  logic [3:0] in_kind     = '0;
  logic [7:0] in_data     = '0;
  logic       out_ready   = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] out_status;
  logic [7:0] out_read_data;
  logic [1:0] out_int_code;
  logic       out_int_pulse;
  logic       out_int_pending;
  logic       out_tx_start;
  logic [7:0] out_tx_byte;
  logic       out_switch_request;
  logic       out_rx_room;

  terminal_char_controller uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_data            (in_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_read_data      (out_read_data),
    .out_int_code       (out_int_code),
    .out_int_pulse      (out_int_pulse),
    .out_int_pending    (out_int_pending),
    .out_tx_start       (out_tx_start),
    .out_tx_byte        (out_tx_byte),
    .out_switch_request (out_switch_request),
    .out_rx_room        (out_rx_room)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Terminal state as the predictor sees it
  logic           unattended;
  tcc_pkg::mode_t term_mode;
  tcc_pkg::dir_t  term_dir;
  logic           term_tx_busy;
  logic [1:0]     term_code;
  logic [7:0]     term_rx_byte;
  logic           term_rx_held;
  logic [7:0]     rx_fifo [tcc_pkg::RX_DEPTH];
  int             fifo_head;
  int             fifo_count;
  logic           timer_running;

  tcc_pkg::result_t pending_responses[$];
  int      n_sent;
  int      n_checked;
  int      n_errors;
  int      idle_cycles;
  logic    no_idle;

  function automatic tcc_pkg::result_t predict_response(input logic [3:0] kind,
                                                        input logic [7:0] data);
    tcc_pkg::result_t r;
    r = '0;
    r.status = tcc_pkg::ST_EVENT;
    case (kind)
      tcc_pkg::KIND_READ: begin
        term_dir = tcc_pkg::DIR_IN;
        if (unattended ? (fifo_count != 0) : term_rx_held) begin
          if (unattended) begin
            r.read_data = rx_fifo[fifo_head];
            fifo_head = (fifo_head + 1) % tcc_pkg::RX_DEPTH;
            fifo_count--;
          end else begin
            r.read_data = term_rx_byte;
            term_rx_held = 1'b0;
          end
          term_mode = tcc_pkg::MODE_OK;
          r.status = tcc_pkg::ST_OK;
        end else begin
          term_mode = tcc_pkg::MODE_EN;
          r.status = tcc_pkg::ST_EN;
        end
      end
      tcc_pkg::KIND_WRITE: begin
        if (!term_tx_busy && term_dir == tcc_pkg::DIR_OUT) begin
          term_mode = tcc_pkg::MODE_OK;
          term_tx_busy = 1'b1;
          r.tx_start = 1'b1;
          r.tx_byte = data;
          r.status = tcc_pkg::ST_OK;
        end else begin
          if (term_dir != tcc_pkg::DIR_OUT && !timer_running) begin
            timer_running = 1'b1;
            r.switch_request = 1'b1;
          end
          term_mode = tcc_pkg::MODE_EN;
          r.status = tcc_pkg::ST_EN;
        end
      end
      tcc_pkg::KIND_DETACH: begin
        if (!term_tx_busy) begin
          term_mode = tcc_pkg::MODE_OFF;
          term_dir = tcc_pkg::DIR_NONE;
          fifo_head = 0;
          fifo_count = 0;
          term_rx_held = 1'b0;
          r.status = tcc_pkg::ST_OK;
        end else begin
          term_mode = tcc_pkg::MODE_EN;
          r.status = tcc_pkg::ST_EN;
        end
      end
      tcc_pkg::KIND_RESET: begin
        term_mode = tcc_pkg::MODE_OFF;
        term_dir = tcc_pkg::DIR_NONE;
        term_tx_busy = 1'b0;
        fifo_head = 0;
        fifo_count = 0;
        term_rx_held = 1'b0;
        r.status = tcc_pkg::ST_OK;
      end
      tcc_pkg::KIND_SPU: begin
        r.status = tcc_pkg::ST_OK;
      end
      tcc_pkg::KIND_INTSPEC: begin
        r.int_code = term_code;
        term_code = tcc_pkg::CODE_OUTDATED;
        term_mode = tcc_pkg::MODE_OK;
        r.status = tcc_pkg::ST_OK;
      end
      tcc_pkg::KIND_RX_CHAR: begin
        if (term_dir == tcc_pkg::DIR_IN && term_mode != tcc_pkg::MODE_OFF) begin
          if (unattended) begin
            if (fifo_count >= tcc_pkg::RX_DEPTH) begin
              term_code = tcc_pkg::CODE_SLOW;
            end else begin
              rx_fifo[(fifo_head + fifo_count) % tcc_pkg::RX_DEPTH] = data;
              fifo_count++;
              if (term_mode == tcc_pkg::MODE_EN) term_code = tcc_pkg::CODE_READY;
            end
          end else begin
            if (term_rx_held) term_code = tcc_pkg::CODE_SLOW;
            else if (term_mode == tcc_pkg::MODE_EN) term_code = tcc_pkg::CODE_READY;
            term_rx_byte = data;
            term_rx_held = 1'b1;
          end
          r.int_pulse = 1'b1;
        end
      end
      tcc_pkg::KIND_TX_DONE: begin
        term_tx_busy = 1'b0;
        if (term_mode == tcc_pkg::MODE_EN) begin
          term_code = tcc_pkg::CODE_READY;
          r.int_pulse = 1'b1;
        end
      end
      tcc_pkg::KIND_SW_TMO: begin
        timer_running = 1'b0;
        if (term_mode != tcc_pkg::MODE_OFF) begin
          term_dir = tcc_pkg::DIR_OUT;
          if (term_mode == tcc_pkg::MODE_EN) begin
            term_code = tcc_pkg::CODE_READY;
            r.int_pulse = 1'b1;
          end
        end
      end
      default: begin
        r.status = tcc_pkg::ST_NO;
      end
    endcase
    r.int_pending = (term_code == tcc_pkg::CODE_READY) || (term_code == tcc_pkg::CODE_SLOW);
    r.rx_room = unattended ? (fifo_count < tcc_pkg::RX_DEPTH) : 1'b1;
    return r;
  endfunction

  function automatic string format_result(input tcc_pkg::result_t r);
    return $sformatf("st=%0d rd=%02h ic=%0d pulse=%b pend=%b txs=%b txb=%02h swr=%b room=%b",
                     r.status, r.read_data, r.int_code, r.int_pulse, r.int_pending,
                     r.tx_start, r.tx_byte, r.switch_request, r.rx_room);
  endfunction

  function automatic string field_diffs(input tcc_pkg::result_t want,
                                        input tcc_pkg::result_t got);
    string s;
    s = "";
    if (got.status !== want.status) s = {s, " status"};
    if (got.read_data !== want.read_data) s = {s, " read_data"};
    if (got.int_code !== want.int_code) s = {s, " int_code"};
    if (got.int_pulse !== want.int_pulse) s = {s, " int_pulse"};
    if (got.int_pending !== want.int_pending) s = {s, " int_pending"};
    if (got.tx_start !== want.tx_start) s = {s, " tx_start"};
    if (got.tx_byte !== want.tx_byte) s = {s, " tx_byte"};
    if (got.switch_request !== want.switch_request) s = {s, " switch_request"};
    if (got.rx_room !== want.rx_room) s = {s, " rx_room"};
    return s;
  endfunction

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic report_mismatch(input string what, input tcc_pkg::result_t want,
                                 input tcc_pkg::result_t got);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("[%0t] mismatch (%s)", $realtime, what);
      $display("  expected %s", format_result(want));
      $display("  actual   %s", format_result(got));
    end
  endtask

  // Hold valid across back-to-back beats; drop it only when a gap is drawn
  task automatic send_beat(input logic [3:0] kind, input logic [7:0] data);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_data  <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_responses.push_back(predict_response(kind, data));
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    unattended = value;
  endtask

  task automatic test_directed_commands();
    send_beat(KIND_UNKNOWN_LO, 8'h00);
    send_beat(KIND_UNKNOWN_HI, 8'hFF);
    send_beat(tcc_pkg::KIND_SPU, 8'h00);
    send_beat(tcc_pkg::KIND_INTSPEC, 8'h00);
    send_beat(tcc_pkg::KIND_RX_CHAR, 8'h81);
    send_beat(tcc_pkg::KIND_SW_TMO, 8'h00);
    send_beat(tcc_pkg::KIND_WRITE, 8'hA5);
    // direction already out and transmitter busy: no switch request
    send_beat(tcc_pkg::KIND_WRITE, 8'h5A);
    // reset command keeps the timer flag and the stored code
    send_beat(tcc_pkg::KIND_RESET, 8'h00);
    send_beat(tcc_pkg::KIND_WRITE, 8'h11);
    send_beat(tcc_pkg::KIND_SW_TMO, 8'hFF);
    send_beat(tcc_pkg::KIND_WRITE, 8'hFF);
    send_beat(tcc_pkg::KIND_DETACH, 8'h00);
    send_beat(tcc_pkg::KIND_WRITE, 8'h00);
    send_beat(tcc_pkg::KIND_TX_DONE, 8'h00);
    send_beat(tcc_pkg::KIND_WRITE, 8'h00);
    send_beat(tcc_pkg::KIND_TX_DONE, 8'hFF);
    send_beat(tcc_pkg::KIND_READ, 8'hFF);
    send_beat(tcc_pkg::KIND_RX_CHAR, 8'h00);
    // overwrite the held byte
    send_beat(tcc_pkg::KIND_RX_CHAR, 8'hFF);
    send_beat(tcc_pkg::KIND_INTSPEC, 8'hFF);
    send_beat(tcc_pkg::KIND_READ, 8'h00);
    send_beat(tcc_pkg::KIND_DETACH, 8'hFF);
    send_beat(KIND_UNKNOWN_LO + 4'd3, 8'h5A);
  endtask

  task automatic test_mode_switch_hold();
    set_mode(1'b0);
    send_beat(tcc_pkg::KIND_READ, 8'h00);
    send_beat(tcc_pkg::KIND_RX_CHAR, 8'h3C);
    set_mode(1'b1);
    send_beat(tcc_pkg::KIND_READ, 8'h00);
    send_beat(tcc_pkg::KIND_RX_CHAR, 8'hC3);
    send_beat(tcc_pkg::KIND_READ, 8'h00);
    set_mode(1'b0);
    send_beat(tcc_pkg::KIND_READ, 8'h00);
  endtask

  task automatic test_fifo_overflow();
    set_mode(1'b1);
    send_beat(tcc_pkg::KIND_RESET, 8'h00);
    send_beat(tcc_pkg::KIND_READ, 8'h00);
    repeat (tcc_pkg::RX_DEPTH + 2) send_beat(tcc_pkg::KIND_RX_CHAR, 8'($urandom));
    send_beat(tcc_pkg::KIND_INTSPEC, 8'h00);
    repeat (tcc_pkg::RX_DEPTH + 1) send_beat(tcc_pkg::KIND_READ, 8'($urandom));
  endtask

  task automatic test_random_traffic();
    int next_flip;
    int n;
    next_flip = n_sent + 200;
    while (n_sent < ITEM_TARGET) begin
      if (n_sent >= next_flip) begin
        set_mode(!unattended);
        next_flip = n_sent + 200;
      end
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_beat(tcc_pkg::KIND_READ, 8'($urandom));
          if (unattended && $urandom_range(0, 5) == 0)
            n = $urandom_range(tcc_pkg::RX_DEPTH - 4, tcc_pkg::RX_DEPTH + 6);
          else n = $urandom_range(1, 6);
          repeat (n) begin
            send_beat(tcc_pkg::KIND_RX_CHAR, 8'($urandom));
            if ($urandom_range(0, 3) == 0) send_beat(tcc_pkg::KIND_READ, 8'($urandom));
          end
          repeat ($urandom_range(0, n + 1)) send_beat(tcc_pkg::KIND_READ, 8'($urandom));
        end
        4, 5: begin
          send_beat(tcc_pkg::KIND_WRITE, 8'($urandom));
          if ($urandom_range(0, 3) == 0) send_beat(tcc_pkg::KIND_WRITE, 8'($urandom));
          send_beat(tcc_pkg::KIND_SW_TMO, 8'($urandom));
          repeat ($urandom_range(1, 4)) begin
            send_beat(tcc_pkg::KIND_WRITE, 8'($urandom));
            if ($urandom_range(0, 2) == 0)
              send_beat($urandom_range(0, 1) ? tcc_pkg::KIND_WRITE : tcc_pkg::KIND_DETACH,
                        8'($urandom));
            if ($urandom_range(0, 7) != 0) send_beat(tcc_pkg::KIND_TX_DONE, 8'($urandom));
          end
        end
        6: begin
          send_beat($urandom_range(0, 1) ? tcc_pkg::KIND_INTSPEC : tcc_pkg::KIND_SPU,
                    8'($urandom));
        end
        7: begin
          send_beat($urandom_range(0, 1) ? tcc_pkg::KIND_DETACH : tcc_pkg::KIND_RESET,
                    8'($urandom));
        end
        default: begin
          repeat ($urandom_range(1, 4)) send_beat(4'($urandom_range(0, 15)), 8'($urandom));
        end
      endcase
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    tcc_pkg::result_t got;
    tcc_pkg::result_t want;
    string   diffs;
    if (rst_n && out_valid && out_ready) begin
      got.status         = out_status;
      got.read_data      = out_read_data;
      got.int_code       = out_int_code;
      got.int_pulse      = out_int_pulse;
      got.int_pending    = out_int_pending;
      got.tx_start       = out_tx_start;
      got.tx_byte        = out_tx_byte;
      got.switch_request = out_switch_request;
      got.rx_room        = out_rx_room;
      if (pending_responses.size() == 0) begin
        report_mismatch("result beat with nothing pending", '0, got);
      end else begin
        want = pending_responses.pop_front();
        n_checked++;
        diffs = field_diffs(want, got);
        if (diffs != "") report_mismatch({"fields:", diffs}, want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_responses.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    n_sent        = 0;
    n_checked     = 0;
    n_errors      = 0;
    idle_cycles   = 0;
    no_idle       = 1'b0;
    unattended    = 1'b0;
    term_mode     = tcc_pkg::MODE_OFF;
    term_dir      = tcc_pkg::DIR_NONE;
    term_tx_busy  = 1'b0;
    term_code     = tcc_pkg::CODE_NONE;
    term_rx_byte  = '0;
    term_rx_held  = 1'b0;
    fifo_head     = 0;
    fifo_count    = 0;
    timer_running = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_commands();
    test_mode_switch_hold();
    test_fifo_overflow();
    test_random_traffic();
    drain();

    n_errors += pending_responses.size();
    $display("Run covered %0d command and event beats, %0d results compared, %0d mismatches,",
             n_sent, n_checked, n_errors);
    $display("across both receive modes, including FIFO overflow, byte overwrite and timer reuse.");
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/tcc_pkg.sv
hdl/tcc_ram.sv
hdl/tcc_ctrl.sv
hdl/terminal_char_controller.sv
hdl/tcc_checker.sv
tb/sv/terminal_char_controller_tb.sv
